// ===== rtl/h2cs_pkg.sv =====
// h2cs_pkg: shared types and constants for the 2-D histogram cdf sampler
// used by h2cs_div and hist2d_cdf_sampler; no dependencies
`default_nettype none

package h2cs_pkg;

  // fixed datapath widths
  localparam int unsigned SumW    = 38;  // running sum within a row
  localparam int unsigned TotW    = 44;  // running total across rows
  localparam int unsigned CoordW  = 17;  // Q0.16 coordinate with room for 1.0
  localparam int unsigned FracW   = 16;  // fraction bits of a coordinate
  localparam int unsigned CfgW    = 7;   // configuration register width
  localparam int unsigned DensW   = 29;  // density result width
  localparam int unsigned DivW    = 44;  // divisor and partial remainder width
  localparam int unsigned StreamW = 28;  // dividend bits shifted in, msb first
  localparam int unsigned IterW   = 5;   // divider step counter width

  localparam logic [CoordW-1:0] OneQ16  = 17'h1_0000;
  localparam logic [DensW-1:0]  DensMax = 29'h1000_0000;

  // operation codes
  localparam logic [1:0] OpLoad    = 2'd0;
  localparam logic [1:0] OpSample  = 2'd1;
  localparam logic [1:0] OpDensity = 2'd2;

  // configuration register indexes
  localparam logic RegCols = 1'b0;
  localparam logic RegRows = 1'b1;

  // request to the shared divider
  typedef struct packed {
    logic                start;
    logic [DivW-1:0]     rem_init;
    logic [StreamW-1:0]  stream;
    logic [DivW-1:0]     divisor;
    logic [IterW-1:0]    iters;
  } div_req_t;

  // answer from the shared divider
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [StreamW-1:0]  quot;
    logic [DivW-1:0]     rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/hist2d_cdf_sampler.sv =====
// hist2d_cdf_sampler: top level of the 2-D histogram cdf sampler
// depends on h2cs_pkg, h2cs_ram and h2cs_div
//
//   channel   handshake            payload
//   --------  -------------------  ---------------------------------------------
//   command   start_i, busy_o      operation_i, first_bin_i, bin_weight_i,
//                                  coord_u_i, coord_v_i
//   result    done_o (one cycle)   ok_o, cell_col_o, cell_row_o, out_u_o,
//                                  out_v_o, density_o
//   config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// a load runs a serial divide that maps the load position to a cell; a sample
// runs the binary searches over row totals and row sums, then the density divide
// and two coordinate divides; a density query reads the bin and runs the density
// divide unless saturated, all on the one-bit-per-cycle shared divider
// reset clears the load position and sums, sets both sizes to 64; tables not cleared
// results cannot be stalled; busy_o is high until the result strobe, none for a load
`default_nettype none

module hist2d_cdf_sampler #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [1:0]  operation_i,
  input  wire         first_bin_i,
  input  wire  [31:0] bin_weight_i,
  input  wire  [16:0] coord_u_i,
  input  wire  [16:0] coord_v_i,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [6:0]  cfg_wdata_i,
  output logic        done_o,
  output logic        ok_o,
  output logic [5:0]  cell_col_o,
  output logic [5:0]  cell_row_o,
  output logic [15:0] out_u_o,
  output logic [15:0] out_v_o,
  output logic [28:0] density_o
);

  import h2cs_pkg::*;

  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CNTW  = $clog2(MAX_COLS + 1);
  localparam int unsigned RNTW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned SW    = (CNTW > RNTW) ? CNTW : RNTW;
  localparam int unsigned Cells = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned PW    = $clog2(Cells + 1);
  localparam int unsigned GoalW = CoordW + TotW;
  localparam int unsigned P1W   = SumW + CNTW;
  localparam int unsigned NumW  = SumW + CNTW + RNTW;
  localparam int unsigned UwW   = CoordW + CNTW;
  localparam int unsigned VhW   = CoordW + RNTW;

  // sequencer state codes
  localparam logic [4:0] StIdle  = 5'd0;
  localparam logic [4:0] StLds   = 5'd1;
  localparam logic [4:0] StLdw   = 5'd2;
  localparam logic [4:0] StLwr   = 5'd3;
  localparam logic [4:0] StRgoal = 5'd4;
  localparam logic [4:0] StSmid  = 5'd5;
  localparam logic [4:0] StScmp  = 5'd6;
  localparam logic [4:0] StRsrd  = 5'd7;
  localparam logic [4:0] StRsum  = 5'd8;
  localparam logic [4:0] StQpos  = 5'd9;
  localparam logic [4:0] StBrd1  = 5'd10;
  localparam logic [4:0] StBrd2  = 5'd11;
  localparam logic [4:0] StBsub  = 5'd12;
  localparam logic [4:0] StMul1  = 5'd13;
  localparam logic [4:0] StMul2  = 5'd14;
  localparam logic [4:0] StDchk  = 5'd15;
  localparam logic [4:0] StDns   = 5'd16;
  localparam logic [4:0] StDnw   = 5'd17;
  localparam logic [4:0] StUds   = 5'd18;
  localparam logic [4:0] StUdw   = 5'd19;
  localparam logic [4:0] StVds   = 5'd20;
  localparam logic [4:0] StVdw   = 5'd21;
  localparam logic [4:0] StFin   = 5'd22;

  // control and load state
  logic [4:0]       state_q, state_d;
  logic             done_q, done_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [SumW-1:0]  crs_q, crs_d;
  logic [TotW-1:0]  grand_q, grand_d;
  logic [CfgW-1:0]  cols_cfg_q, cols_cfg_d;
  logic [CfgW-1:0]  rows_cfg_q, rows_cfg_d;

  // per item datapath
  logic [1:0]        op_q, op_d;
  logic [31:0]       weight_q, weight_d;
  logic [CoordW-1:0] u_q, u_d;
  logic [CoordW-1:0] v_q, v_d;
  logic [SW-1:0]     lo_q, lo_d;
  logic [SW-1:0]     hi_q, hi_d;
  logic [SW-1:0]     mid_q, mid_d;
  logic              srch_col_q, srch_col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [GoalW-1:0]  goal_q, goal_d;
  logic [SumW-1:0]   hisum_q, hisum_d;
  logic [SumW-1:0]   bin_q, bin_d;
  logic [P1W-1:0]    prod1_q, prod1_d;
  logic [NumW-1:0]   num_q, num_d;
  logic              ok_q, ok_d;
  logic [15:0]       ou_q, ou_d;
  logic [15:0]       ov_q, ov_d;
  logic [DensW-1:0]  dens_q, dens_d;

  // effective sizes
  logic [CNTW-1:0]      w;
  logic [RNTW-1:0]      h;
  logic [CNTW+RNTW-1:0] wh;

  // tables
  logic            rs_we, tot_we;
  logic [AW-1:0]   rs_waddr, rs_raddr;
  logic [SumW-1:0] rs_wdata, rs_rdata;
  logic [RW-1:0]   tot_raddr;
  logic [TotW-1:0] tot_wdata, tot_rdata;
  logic [CW-1:0]   ridx;

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // misc combinational
  logic [SW:0]       mid_sum;
  logic [SW-1:0]     mid;
  logic [TotW-1:0]   cmp_data;
  logic              cmp_ge;
  logic [SumW-1:0]   crs_new;
  logic [TotW-1:0]   grand_new;
  logic              last_col;
  logic [UwW-1:0]    uw;
  logic [VhW-1:0]    vh;
  logic [CoordW-1:0] u_clip, v_clip;
  logic [PW-1:0]     pos_eff;
  logic              dens_sat;

  // clamp register values to 1..max
  always_comb begin
    if (cols_cfg_q == '0) begin
      w = CNTW'(1);
    end else if (32'(cols_cfg_q) > MAX_COLS) begin
      w = CNTW'(MAX_COLS);
    end else begin
      w = CNTW'(cols_cfg_q);
    end
    if (rows_cfg_q == '0) begin
      h = RNTW'(1);
    end else if (32'(rows_cfg_q) > MAX_ROWS) begin
      h = RNTW'(MAX_ROWS);
    end else begin
      h = RNTW'(rows_cfg_q);
    end
    wh = (CNTW+RNTW)'(w) * (CNTW+RNTW)'(h);
  end

  // shared compare, sums and scaled coordinates
  always_comb begin
    mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
    mid       = mid_sum[SW:1];
    cmp_data  = srch_col_q ? TotW'(rs_rdata) : tot_rdata;
    cmp_ge    = (GoalW'({cmp_data, 16'h0}) >= goal_q);
    crs_new   = crs_q + SumW'(weight_q);
    grand_new = grand_q + TotW'(crs_new);
    last_col  = (CNTW'(col_q) == (w - CNTW'(1)));
    uw        = UwW'(u_q) * UwW'(w);
    vh        = VhW'(v_q) * VhW'(h);
    u_clip    = (coord_u_i > OneQ16) ? OneQ16 : coord_u_i;
    v_clip    = (coord_v_i > OneQ16) ? OneQ16 : coord_v_i;
    pos_eff   = first_bin_i ? '0 : pos_q;
    dens_sat  = (64'(num_q) >= (64'(grand_q) << 12));
  end

  // table addressing
  always_comb begin
    case (state_q)
      StSmid:  ridx = CW'(mid);
      StRsrd:  ridx = CW'(w - CNTW'(1));
      StBrd2:  ridx = col_q - CW'(1);
      default: ridx = col_q;
    endcase
    rs_raddr  = AW'(32'(row_q) * MAX_COLS + 32'(ridx));
    tot_raddr = RW'(mid);
    rs_we     = (state_q == StLwr);
    rs_waddr  = AW'(32'(row_q) * MAX_COLS + 32'(col_q));
    rs_wdata  = crs_new;
    tot_we    = (state_q == StLwr) && last_col;
    tot_wdata = grand_new;
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state_q)
      StLds: begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.stream   = StreamW'(pos_q) << (StreamW - PW);
        div_req.divisor  = DivW'(w);
        div_req.iters    = IterW'(PW);
      end
      StDns: begin
        div_req.start    = 1'b1;
        div_req.rem_init = DivW'(num_q >> 12);
        div_req.stream   = {num_q[11:0], 16'h0};
        div_req.divisor  = grand_q;
        div_req.iters    = IterW'(StreamW);
      end
      StUds: begin
        div_req.start    = 1'b1;
        div_req.rem_init = DivW'(col_q);
        div_req.stream   = {uw[FracW-1:0], 12'h0};
        div_req.divisor  = DivW'(w);
        div_req.iters    = IterW'(FracW);
      end
      StVds: begin
        div_req.start    = 1'b1;
        div_req.rem_init = DivW'(row_q);
        div_req.stream   = {vh[FracW-1:0], 12'h0};
        div_req.divisor  = DivW'(h);
        div_req.iters    = IterW'(FracW);
      end
      default: div_req = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    pos_d      = pos_q;
    crs_d      = crs_q;
    grand_d    = grand_q;
    cols_cfg_d = cols_cfg_q;
    rows_cfg_d = rows_cfg_q;
    op_d       = op_q;
    weight_d   = weight_q;
    u_d        = u_q;
    v_d        = v_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    srch_col_d = srch_col_q;
    row_d      = row_q;
    col_d      = col_q;
    goal_d     = goal_q;
    hisum_d    = hisum_q;
    bin_d      = bin_q;
    prod1_d    = prod1_q;
    num_d      = num_q;
    ok_d       = ok_q;
    ou_d       = ou_q;
    ov_d       = ov_q;
    dens_d     = dens_q;

    // configuration writes
    if (cfg_we_i) begin
      if (cfg_idx_i == RegCols) begin
        cols_cfg_d = cfg_wdata_i;
      end else begin
        rows_cfg_d = cfg_wdata_i;
      end
    end

    case (state_q)
      StIdle: begin
        if (start_i) begin
          op_d     = operation_i;
          weight_d = bin_weight_i;
          u_d      = u_clip;
          v_d      = v_clip;
          case (operation_i)
            OpLoad: begin
              if (first_bin_i) begin
                pos_d   = '0;
                crs_d   = '0;
                grand_d = '0;
              end
              if (32'(pos_eff) < 32'(wh)) begin
                state_d = StLds;
              end
            end
            OpSample, OpDensity: begin
              ok_d   = 1'b0;
              col_d  = '0;
              row_d  = '0;
              ou_d   = '0;
              ov_d   = '0;
              dens_d = '0;
              if (grand_q == '0) begin
                state_d = StFin;
              end else if (operation_i == OpSample) begin
                state_d = StRgoal;
              end else begin
                state_d = StQpos;
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end
      // load: split the position into row and column
      StLds: state_d = StLdw;
      StLdw: begin
        if (div_rsp.done) begin
          row_d   = RW'(div_rsp.quot);
          col_d   = CW'(div_rsp.rem);
          state_d = StLwr;
        end
      end
      StLwr: begin
        if (last_col) begin
          grand_d = grand_new;
          crs_d   = '0;
        end else begin
          crs_d = crs_new;
        end
        pos_d   = pos_q + PW'(1);
        state_d = StIdle;
      end
      // row search setup
      StRgoal: begin
        goal_d     = GoalW'(v_q) * GoalW'(grand_q);
        lo_d       = '0;
        hi_d       = SW'(h);
        srch_col_d = 1'b0;
        state_d    = StSmid;
      end
      // binary search step: issue read at mid
      StSmid: begin
        if (lo_q < hi_q) begin
          mid_d   = mid;
          state_d = StScmp;
        end else if (!srch_col_q) begin
          if (32'(lo_q) < 32'(h)) begin
            row_d   = RW'(lo_q);
            ok_d    = 1'b1;
            state_d = StRsrd;
          end else begin
            row_d   = '0;
            state_d = StFin;
          end
        end else begin
          if (32'(lo_q) >= 32'(w)) begin
            col_d = CW'(w - CNTW'(1));
          end else begin
            col_d = CW'(lo_q);
          end
          state_d = StBrd1;
        end
      end
      // binary search step: compare and narrow
      StScmp: begin
        if (cmp_ge) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + SW'(1);
        end
        state_d = StSmid;
      end
      // row sum read, then column search setup
      StRsrd: state_d = StRsum;
      StRsum: begin
        goal_d     = GoalW'(u_q) * GoalW'(rs_rdata);
        lo_d       = '0;
        hi_d       = SW'(w);
        srch_col_d = 1'b1;
        state_d    = StSmid;
      end
      // density query: cell from position
      StQpos: begin
        if (32'(uw >> FracW) >= 32'(w)) begin
          col_d = CW'(w - CNTW'(1));
        end else begin
          col_d = CW'(uw >> FracW);
        end
        if (32'(vh >> FracW) >= 32'(h)) begin
          row_d = RW'(h - RNTW'(1));
        end else begin
          row_d = RW'(vh >> FracW);
        end
        ok_d    = 1'b1;
        state_d = StBrd1;
      end
      // bin weight from neighboring running sums
      StBrd1: state_d = StBrd2;
      StBrd2: begin
        hisum_d = rs_rdata;
        state_d = StBsub;
      end
      StBsub: begin
        bin_d   = (col_q != '0) ? (hisum_q - rs_rdata) : hisum_q;
        state_d = StMul1;
      end
      StMul1: begin
        prod1_d = P1W'(bin_q) * P1W'(w);
        state_d = StMul2;
      end
      StMul2: begin
        num_d   = NumW'(prod1_q) * NumW'(h);
        state_d = StDchk;
      end
      StDchk: begin
        if (dens_sat) begin
          dens_d  = DensMax;
          state_d = (op_q == OpSample) ? StUds : StFin;
        end else begin
          state_d = StDns;
        end
      end
      StDns: state_d = StDnw;
      StDnw: begin
        if (div_rsp.done) begin
          dens_d  = DensW'(div_rsp.quot);
          state_d = (op_q == OpSample) ? StUds : StFin;
        end
      end
      // continuous coordinates
      StUds: state_d = StUdw;
      StUdw: begin
        if (div_rsp.done) begin
          ou_d    = div_rsp.quot[FracW-1:0];
          state_d = StVds;
        end
      end
      StVds: state_d = StVdw;
      StVdw: begin
        if (div_rsp.done) begin
          ov_d    = div_rsp.quot[FracW-1:0];
          state_d = StFin;
        end
      end
      StFin: begin
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      done_q     <= 1'b0;
      pos_q      <= '0;
      crs_q      <= '0;
      grand_q    <= '0;
      cols_cfg_q <= 7'd64;
      rows_cfg_q <= 7'd64;
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      pos_q      <= pos_d;
      crs_q      <= crs_d;
      grand_q    <= grand_d;
      cols_cfg_q <= cols_cfg_d;
      rows_cfg_q <= rows_cfg_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    weight_q   <= weight_d;
    u_q        <= u_d;
    v_q        <= v_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    srch_col_q <= srch_col_d;
    row_q      <= row_d;
    col_q      <= col_d;
    goal_q     <= goal_d;
    hisum_q    <= hisum_d;
    bin_q      <= bin_d;
    prod1_q    <= prod1_d;
    num_q      <= num_d;
    ok_q       <= ok_d;
    ou_q       <= ou_d;
    ov_q       <= ov_d;
    dens_q     <= dens_d;
  end

  // running sums within each row
  h2cs_ram #(
    .Width (SumW),
    .Depth (Cells)
  ) u_rs_ram (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (rs_wdata),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  // cumulative totals at the end of each row
  h2cs_ram #(
    .Width (TotW),
    .Depth (MAX_ROWS)
  ) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (row_q),
    .wdata_i (tot_wdata),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rdata)
  );

  h2cs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // outputs
  assign busy_o     = (state_q != StIdle);
  assign done_o     = done_q;
  assign ok_o       = ok_q;
  assign cell_col_o = 6'(col_q);
  assign cell_row_o = 6'(row_q);
  assign out_u_o    = ou_q;
  assign out_v_o    = ov_q;
  assign density_o  = dens_q;

`ifndef SYNTHESIS
  // the result strobe only follows the final sequencer step
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == StFin))
    else $error("result strobe without final step");

  // the divider is never asked to start while it is still working
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a failed query reports all zero fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (density_o == '0 && out_u_o == '0 && out_v_o == '0 &&
                           cell_col_o == '0 && cell_row_o == '0))
    else $error("failed query with nonzero fields");

  // density never exceeds the saturation value
  a_dens_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (density_o <= DensMax))
    else $error("density above saturation");
`endif

endmodule

`default_nettype wire

// ===== rtl/h2cs_ram.sv =====
// h2cs_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module h2cs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                                          clk_i,
  input  wire                                          we_i,
  input  wire  [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire  [Width-1:0]                             wdata_i,
  input  wire  [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/h2cs_div.sv =====
// h2cs_div: shared restoring divider, one quotient bit per cycle
// depends on h2cs_pkg for the request and answer structs
`default_nettype none

module h2cs_div (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  h2cs_pkg::div_req_t    req_i,
  output h2cs_pkg::div_rsp_t    rsp_o
);

  import h2cs_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [IterW-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]   r_q, r_d;
  logic [StreamW-1:0] s_q, s_d;
  logic [StreamW-1:0] q_q, q_d;
  logic [DivW-1:0]   d_q, d_d;

  logic [DivW:0]     r2;
  logic [DivW:0]     diff;
  logic              ge;

  // one trial subtraction per cycle
  always_comb begin
    r2   = {r_q, s_q[StreamW-1]};
    diff = r2 - {1'b0, d_q};
    ge   = (r2 >= {1'b0, d_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    s_d    = s_q;
    q_d    = q_q;
    d_d    = d_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      r_d    = req_i.rem_init;
      s_d    = req_i.stream;
      q_d    = '0;
      d_d    = req_i.divisor;
    end else if (busy_q) begin
      r_d   = ge ? diff[DivW-1:0] : r2[DivW-1:0];
      s_d   = {s_q[StreamW-2:0], 1'b0};
      q_d   = {q_q[StreamW-2:0], ge};
      cnt_d = cnt_q - IterW'(1);
      if (cnt_q == IterW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    s_q <= s_d;
    q_q <= q_d;
    d_q <= d_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q;

endmodule

`default_nettype wire
